// ===== src/rss_pkg.sv =====
// Shared types and constants for the running sample statistics block.
// Used by the front, queue, back and top-level modules; no dependencies.
package rss_pkg;

    localparam int unsigned MAX_COUNT  = 65536;
    localparam int unsigned CNT_W      = 17;
    localparam int unsigned SUM_W      = 33;
    localparam int unsigned SQS_W      = 47;
    localparam int unsigned SMP_W      = 16;
    localparam int unsigned VAR_W      = 48;
    localparam int unsigned DEV_W      = 32;
    localparam int unsigned MEAN_W     = 32;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned PROD_W     = 64;
    localparam int unsigned DEN_W      = 32;
    localparam int unsigned DIFF_W     = 63;
    localparam int unsigned VDVD_W     = DIFF_W + FRAC_W;
    localparam int unsigned MNUM_W     = 48;
    localparam int unsigned ITER_W     = 7;

    localparam logic [CNT_W-1:0] MAX_COUNT_C = CNT_W'(MAX_COUNT);

    // One snapshot of the running statistics, handed from front to back.
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
        logic [SQS_W-1:0]        sqsum;
        logic signed [SMP_W-1:0] minv;
        logic signed [SMP_W-1:0] maxv;
        logic                    full;
    } t_snap;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== src/rss_front.sv =====
// Front end: accepts samples and keeps count, sum, sum of squares, min, max.
// Depends on rss_pkg; pushes one snapshot per accepted word into the queue.
module rss_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [15:0]   i_sample,
    input  rss_pkg::t_q_stat     i_q_stat,
    output logic                 o_stall,
    output logic                 o_push,
    output rss_pkg::t_snap       o_snap
);
    logic [rss_pkg::CNT_W-1:0]        r_count, n_count;
    logic signed [rss_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [rss_pkg::SQS_W-1:0]        r_sqsum, n_sqsum;
    logic signed [15:0]               r_min, n_min, r_max, n_max;
    logic                             is_full;
    logic                             take;
    logic [15:0]                      mag;
    logic [31:0]                      sq;

    assign o_stall = i_q_stat.full;
    assign take    = i_valid && !i_q_stat.full;
    assign is_full = r_count >= rss_pkg::MAX_COUNT_C;
    assign mag     = i_sample[15] ? 16'(-i_sample) : 16'(i_sample);
    assign sq      = mag * mag;

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_sqsum = r_sqsum;
        n_min   = r_min;
        n_max   = r_max;
        if (!is_full) begin
            n_count = r_count + 1'b1;
            n_sum   = r_sum + rss_pkg::SUM_W'(i_sample);
            n_sqsum = r_sqsum + rss_pkg::SQS_W'(sq);
            if (i_sample < r_min) n_min = i_sample;
            if (i_sample > r_max) n_max = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sqsum <= '0;
            r_min   <= 16'sh7FFF;
            r_max   <= 16'sh8000;
        end else if (take) begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_sqsum <= n_sqsum;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    assign o_push       = take;
    assign o_snap.count = n_count;
    assign o_snap.sum   = n_sum;
    assign o_snap.sqsum = n_sqsum;
    assign o_snap.minv  = n_min;
    assign o_snap.maxv  = n_max;
    assign o_snap.full  = is_full;
endmodule

// ===== src/rss_queue.sv =====
// Two-entry queue of statistics snapshots between front and back.
// Depends on rss_pkg for the snapshot and status types.
module rss_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rss_pkg::t_snap   i_snap,
    input  logic             i_pop,
    output rss_pkg::t_snap   o_snap,
    output rss_pkg::t_q_stat o_stat
);
    rss_pkg::t_snap r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_snap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_snap       = r_mem[r_rp];
    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;
endmodule

// ===== src/rss_back.sv =====
// Back end: mean divider, variance numerator, variance divider and square root.
// Depends on rss_pkg; pops snapshots from the queue and holds the result word.
module rss_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rss_pkg::t_snap        i_snap,
    input  rss_pkg::t_q_stat      i_q_stat,
    output logic                  o_pop,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [16:0]           o_sample_count,
    output logic signed [31:0]    o_mean_value,
    output logic signed [15:0]    o_min_value,
    output logic signed [15:0]    o_max_value,
    output logic [47:0]           o_variance_value,
    output logic [31:0]           o_deviation_value,
    output logic                  o_spread_valid,
    output logic                  o_full_flag
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_VDIV = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [rss_pkg::ITER_W-1:0] MUL_ITERS  = rss_pkg::ITER_W'(rss_pkg::CNT_W);
    localparam logic [rss_pkg::ITER_W-1:0] VDIV_ITERS = rss_pkg::ITER_W'(rss_pkg::VDVD_W);
    localparam logic [rss_pkg::ITER_W-1:0] SQRT_ITERS = rss_pkg::ITER_W'(rss_pkg::DEV_W);
    localparam logic [rss_pkg::ITER_W-1:0] MDIV_ITERS = rss_pkg::ITER_W'(rss_pkg::MNUM_W);

    logic [2:0]                        r_state;
    logic [rss_pkg::ITER_W-1:0]        r_cnt;
    rss_pkg::t_snap                    r_snap;
    logic [31:0]                       r_smag;
    logic                              r_neg;

    logic [rss_pkg::PROD_W-1:0]        r_acc, r_mcand, r_sq;
    logic [rss_pkg::CNT_W-1:0]         r_mplier;
    logic [rss_pkg::DEN_W-1:0]         r_den;
    logic [rss_pkg::VDVD_W-1:0]        r_dvd;
    logic [rss_pkg::DEN_W-1:0]         r_rem;
    logic [rss_pkg::VAR_W-1:0]         r_var;
    logic [63:0]                       r_sx;
    logic [32:0]                       r_srem;
    logic [31:0]                       r_root;

    logic                              r_mbusy;
    logic [rss_pkg::ITER_W-1:0]        r_mcnt;
    logic [rss_pkg::MNUM_W-1:0]        r_mnum;
    logic [rss_pkg::CNT_W-1:0]         r_mrem;
    logic [31:0]                       r_mq;

    logic                              r_out_valid;
    logic                              start;
    logic                              finish;
    logic [32:0]                       sum_abs;
    logic [32:0]                       vtrial;
    logic [34:0]                       strial;
    logic [33:0]                       sroot;
    logic [17:0]                       mtrial;
    logic [rss_pkg::PROD_W-1:0]        diff;
    logic [31:0]                       mean_mag;

    assign start   = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_pop   = start;
    assign finish  = (r_state == S_DONE) && !r_mbusy && (!r_out_valid || !i_out_stall);
    assign sum_abs = i_snap.sum[32] ? 33'(-i_snap.sum) : 33'(i_snap.sum);
    assign vtrial  = {r_rem, r_dvd[rss_pkg::VDVD_W-1]};
    assign strial  = {r_srem, r_sx[63:62]};
    assign sroot   = {r_root, 2'b01};
    assign mtrial  = {r_mrem, r_mnum[rss_pkg::MNUM_W-1]};
    assign diff    = r_acc - r_sq;
    assign mean_mag = r_mq + 32'(r_mrem != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mbusy <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_state <= (i_snap.count >= rss_pkg::CNT_W'(2)) ? S_MUL : S_DONE;
                    r_mbusy <= i_snap.count != '0;
                end
                S_MUL:  if (r_cnt == MUL_ITERS - 1'b1) r_state <= S_SQ;
                S_SQ:   r_state <= S_LOAD;
                S_LOAD: r_state <= S_VDIV;
                S_VDIV: if (r_cnt == VDIV_ITERS - 1'b1) r_state <= S_SQRT;
                S_SQRT: if (r_cnt == SQRT_ITERS - 1'b1) r_state <= S_DONE;
                S_DONE: if (finish) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (r_mbusy && r_mcnt == MDIV_ITERS - 1'b1) r_mbusy <= 1'b0;
        end
    end

    // Datapath: shift-add multiply, restoring division and digit-by-digit root.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cnt    <= '0;
                r_snap   <= i_snap;
                r_smag   <= sum_abs[31:0];
                r_neg    <= i_snap.sum[32];
                r_acc    <= '0;
                r_mcand  <= rss_pkg::PROD_W'(i_snap.sqsum);
                r_mplier <= i_snap.count;
                r_var    <= '0;
                r_root   <= '0;
            end
            S_MUL: begin
                if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 1'b1;
            end
            S_SQ: begin
                r_sq  <= r_smag * r_smag;
                r_den <= rss_pkg::DEN_W'(r_snap.count * (r_snap.count - 1'b1));
                r_cnt <= '0;
            end
            S_LOAD: begin
                r_dvd <= {diff[rss_pkg::DIFF_W-1:0], {rss_pkg::FRAC_W{1'b0}}};
                r_rem <= '0;
            end
            S_VDIV: begin
                if (vtrial >= {1'b0, r_den}) begin
                    r_rem <= rss_pkg::DEN_W'(vtrial - {1'b0, r_den});
                    r_var <= {r_var[rss_pkg::VAR_W-2:0], 1'b1};
                end else begin
                    r_rem <= vtrial[rss_pkg::DEN_W-1:0];
                    r_var <= {r_var[rss_pkg::VAR_W-2:0], 1'b0};
                end
                r_dvd <= r_dvd << 1;
                if (r_cnt == VDIV_ITERS - 1'b1) begin
                    r_cnt  <= '0;
                    r_srem <= '0;
                    r_root <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_SQRT: begin
                if (r_cnt == '0) begin
                    // First step takes the top digit of the freshly scaled variance.
                    r_sx   <= {r_var[rss_pkg::VAR_W-3:0], {rss_pkg::FRAC_W{1'b0}}, 2'b00};
                    if ({33'd0, r_var[rss_pkg::VAR_W-1 -: 2]} >= 35'd1) begin
                        r_srem <= 33'({33'd0, r_var[rss_pkg::VAR_W-1 -: 2]} - 35'd1);
                        r_root <= 32'd1;
                    end else begin
                        r_srem <= 33'(r_var[rss_pkg::VAR_W-1 -: 2]);
                        r_root <= 32'd0;
                    end
                end else begin
                    r_sx <= r_sx << 2;
                    if (strial >= {1'b0, sroot}) begin
                        r_srem <= 33'(strial - {1'b0, sroot});
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_srem <= strial[32:0];
                        r_root <= {r_root[30:0], 1'b0};
                    end
                end
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    // The mean divider runs alongside the variance sequence.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_mcnt <= '0;
            r_mnum <= {sum_abs[31:0], {rss_pkg::FRAC_W{1'b0}}};
            r_mrem <= '0;
            r_mq   <= '0;
        end else if (r_mbusy) begin
            if (mtrial >= {1'b0, r_snap.count}) begin
                r_mrem <= rss_pkg::CNT_W'(mtrial - {1'b0, r_snap.count});
                r_mq   <= {r_mq[30:0], 1'b1};
            end else begin
                r_mrem <= mtrial[rss_pkg::CNT_W-1:0];
                r_mq   <= {r_mq[30:0], 1'b0};
            end
            r_mnum <= r_mnum << 1;
            r_mcnt <= r_mcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            o_sample_count    <= r_snap.count;
            if (r_snap.count == '0) o_mean_value <= '0;
            else if (r_neg)         o_mean_value <= -$signed(mean_mag);
            else                    o_mean_value <= $signed(r_mq);
            o_min_value       <= r_snap.minv;
            o_max_value       <= r_snap.maxv;
            o_variance_value  <= r_var;
            o_deviation_value <= r_root;
            o_spread_valid    <= r_snap.count >= rss_pkg::CNT_W'(2);
            o_full_flag       <= r_snap.full;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ===== src/running_sample_statistics.sv =====
// Running sample statistics: count, mean, min, max, variance and deviation.
// The back end handles one word at a time with its serial multiply,
// 79-step variance divider and 32-step square root; the two-entry queue
// lets the front accept new words meanwhile until the queue is full.
// Reset is synchronous and active low; it clears all statistics and the queue.
module running_sample_statistics (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_sample,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [16:0]         o_sample_count,
    output logic signed [31:0]  o_mean_value,
    output logic signed [15:0]  o_min_value,
    output logic signed [15:0]  o_max_value,
    output logic [47:0]         o_variance_value,
    output logic [31:0]         o_deviation_value,
    output logic                o_spread_valid,
    output logic                o_full_flag
);
    rss_pkg::t_snap   push_snap, head_snap;
    rss_pkg::t_q_stat q_stat;
    logic             push, pop;

    rss_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_sample (i_sample),
        .i_q_stat (q_stat),
        .o_stall  (o_in_stall),
        .o_push   (push),
        .o_snap   (push_snap)
    );

    rss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_snap  (push_snap),
        .i_pop   (pop),
        .o_snap  (head_snap),
        .o_stat  (q_stat)
    );

    rss_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_snap            (head_snap),
        .i_q_stat          (q_stat),
        .o_pop             (pop),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_sample_count    (o_sample_count),
        .o_mean_value      (o_mean_value),
        .o_min_value       (o_min_value),
        .o_max_value       (o_max_value),
        .o_variance_value  (o_variance_value),
        .o_deviation_value (o_deviation_value),
        .o_spread_valid    (o_spread_valid),
        .o_full_flag       (o_full_flag)
    );

    a_spread_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_spread_valid == (o_sample_count >= 17'd2)))
        else $error("spread flag disagrees with sample count");

    a_no_spread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_spread_valid) |-> (o_variance_value == '0 && o_deviation_value == '0))
        else $error("variance reported with fewer than two samples");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_count != '0))
        else $error("result word with zero samples");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_min_value <= o_max_value))
        else $error("minimum above maximum");
endmodule

// ===== tb/running_sample_statistics_test.sv =====
// Testbench for running_sample_statistics: drives sample words, predicts each
// result word from running sums and checks it. Depends on rss_pkg and the block.
`timescale 1ns / 100ps

module running_sample_statistics_test;

    typedef struct {
        logic [16:0]        count;
        logic signed [31:0] mean;
        logic signed [15:0] minv;
        logic signed [15:0] maxv;
        logic [47:0]        var_q;
        logic [31:0]        dev;
        logic               spread;
        logic               full;
    } t_stats_word;

    int error_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    class stats_scoreboard;
        logic [16:0]          n_acc;
        logic signed [63:0]   total;
        logic [63:0]          sq_total;
        logic signed [15:0]   lowest;
        logic signed [15:0]   highest;
        t_stats_word          pending[$];

        function new();
            n_acc = 0;
            total = 0;
            sq_total = 0;
            lowest = 16'sh7fff;
            highest = -16'sh8000;
        endfunction

        static function logic [63:0] int_sqrt(input logic [63:0] x);
            logic [63:0] root;
            logic [63:0] probe;
            root = 0;
            probe = 64'd1 << 62;
            while (probe > x) probe >>= 2;
            while (probe != 0) begin
                if (x >= root + probe) begin
                    x -= root + probe;
                    root = (root >> 1) + probe;
                end else begin
                    root >>= 1;
                end
                probe >>= 2;
            end
            return root;
        endfunction

        function void note_sample(input logic signed [15:0] smp);
            t_stats_word w;
            logic [63:0] mag, num, diff, den, quo, rem, nn;
            w.full = (n_acc >= rss_pkg::MAX_COUNT_C);
            if (!w.full) begin
                n_acc++;
                total += smp;
                sq_total += 64'(longint'(smp) * longint'(smp));
                if (smp < lowest) lowest = smp;
                if (smp > highest) highest = smp;
            end
            nn = n_acc;
            mag = total < 0 ? 64'(-total) : 64'(total);
            num = mag << 16;
            w.mean = 0;
            if (nn != 0)
                w.mean = total < 0 ? 32'(-longint'((num + nn - 1) / nn)) : 32'(num / nn);
            w.var_q = 0;
            w.dev = 0;
            if (nn >= 2) begin
                diff = nn * sq_total - mag * mag;
                den = nn * (nn - 1);
                quo = diff / den;
                rem = diff % den;
                w.var_q = 48'((quo << 16) + ((rem << 16) / den));
                w.dev = 32'(int_sqrt({16'd0, w.var_q} << 16));
            end
            w.count = n_acc;
            w.minv = lowest;
            w.maxv = highest;
            w.spread = nn >= 2;
            pending = {pending, w};
        endfunction

        task check_word(input t_stats_word got);
            t_stats_word e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word, count", got.count, -1);
                return;
            end
            e = pending.pop_front();
            if (got.count !== e.count) report_mismatch("count", got.count, e.count);
            if (got.mean !== e.mean) report_mismatch("mean", got.mean, e.mean);
            if (got.minv !== e.minv) report_mismatch("min", got.minv, e.minv);
            if (got.maxv !== e.maxv) report_mismatch("max", got.maxv, e.maxv);
            if (got.var_q !== e.var_q) report_mismatch("variance", got.var_q, e.var_q);
            if (got.dev !== e.dev) report_mismatch("deviation", got.dev, e.dev);
            if (got.spread !== e.spread) report_mismatch("spread", got.spread, e.spread);
            if (got.full !== e.full) report_mismatch("full", got.full, e.full);
        endtask
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic signed [15:0] sample = 0;
    logic               out_stall = 1;
    logic               in_stall, out_valid;
    logic [16:0]        o_count;
    logic signed [31:0] o_mean;
    logic signed [15:0] o_min, o_max;
    logic [47:0]        o_var;
    logic [31:0]        o_dev;
    logic               o_spread, o_full;

    int send_idle_pct = 8;
    int recv_idle_pct = 57;
    bit holding = 1'b0;
    event hold_ev;

    stats_scoreboard sb = new();

    running_sample_statistics dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_sample(sample),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_sample_count(o_count), .o_mean_value(o_mean),
        .o_min_value(o_min), .o_max_value(o_max),
        .o_variance_value(o_var), .o_deviation_value(o_dev),
        .o_spread_valid(o_spread), .o_full_flag(o_full)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Counts out the long receiver hold-off each time one is requested.
    initial begin
        forever begin
            @(hold_ev);
            holding <= 1'b1;
            repeat (2000) @(posedge clk);
            holding <= 1'b0;
        end
    end

    // Receiver: random stall, plus a long hold-off when requested.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b1;
        end else begin
            if (out_valid && !out_stall)
                sb.check_word('{o_count, o_mean, o_min, o_max, o_var, o_dev,
                                o_spread, o_full});
            if (holding) begin
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Offers one sample word and waits until it is taken.
    task automatic send_sample(input logic signed [15:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= smp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_sample(smp);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(40)) - 16'sd20;
            2: return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(3))
                                        : -16'sh8000 + 16'($urandom_range(3));
            default: return 16'($urandom_range(2000)) - 16'sd1000;
        endcase
    endfunction

    initial begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one sample alone, then extremes and equal values.
        send_sample(16'sd5);
        send_sample(16'sd5);
        send_sample(-16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(-16'sh8000);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(-16'sh5556);
        send_sample(-16'sd7);
        drain_results();

        for (int i = 0; i < 650; i++) begin
            if (i == 200) begin
                send_idle_pct = 57;
                recv_idle_pct = 8;
            end
            if (i == 420) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Long receiver hold-off: the block fills and stalls its input.
            if (i == 100 || i == 500) -> hold_ev;
            // Sender pause until everything has come out.
            if (i == 300) drain_results();
            send_sample(random_sample());
        end

        drain_results();
        repeat (300) @(posedge clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/rss_pkg.sv
src/rss_front.sv
src/rss_queue.sv
src/rss_back.sv
src/running_sample_statistics.sv
tb/running_sample_statistics_test.sv
